// ===== sv/plid_pkg.sv =====
package plid_pkg;

  // Default list capacity and the fixed widths of the words.
  localparam int CAPACITY_DEF = 32;
  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int CNT_OUT_W    = 7;

  // Command codes carried by an input word.
  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_POS  = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_POS  = 3'd4,
    CMD_DEL_TAIL = 3'd5,
    CMD_DISPLAY  = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_t;

  // Status codes carried by a result word.
  typedef enum logic [1:0] {
    ST_LISTED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]              command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_OUT_W-1:0]    element_count;
    logic                    last;
  } out_word_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_DONE,
    S_STREAM_RD,
    S_STREAM_LD,
    S_STATUS
  } plid_state_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START_INS,
    OP_START_DEL,
    OP_REWIND,
    OP_RD_PREV,
    OP_WR_DOWN,
    OP_PUT,
    OP_RD_NEXT,
    OP_WR_UP,
    OP_DEL_DONE,
    OP_RD_CUR,
    OP_EMIT,
    OP_STATUS
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic ptr_at_idx;
    logic ptr_at_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/positional_list_insert_delete.sv =====
// Positional list: an ordered list of up to CAPACITY signed 32-bit values.
// The input channel (in_valid, in_stall, in_word) takes one command word:
// insert at head, position or tail, delete at head, position or tail, or
// display. The result channel (out_valid, out_stall, out_word) returns the
// whole list head first, one word per element with the count and a last
// flag, or a single status word (list empty, invalid position, list full).
// Command code 7 is dropped and gives no result.
// Commands are handled one at a time. A shift moves one element at a time
// through the list store, by a read state and then a write state, so an
// insert at index i moves length-i elements and a delete at index i moves
// length-1-i elements to update the list. Streaming then reads each
// element in a read state and loads it into the output register in a load
// state; a status word is loaded into the output register from the status state.
// The output register holds a finished word while the receiver stalls; the
// block takes a new command as soon as the previous one has loaded its last
// word, and streaming pauses while a held word is stalled by out_stall.
// Reset empties the list and clears any pending result; it needs no
// clearing pass since list entries are only read below the current length.
module positional_list_insert_delete
  import plid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_word.command),
    .stat       (stat),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  plid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== sv/plid_ctrl.sv =====
module plid_ctrl
  import plid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [2:0] in_command,
  input  dp_stat_t stat,
  output logic     in_stall,
  output dp_cmd_t  cmd
);

  plid_state_t state_r, state_nxt;
  status_t     code_r, code_nxt;

  // State and pending status code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
              if (in_command == CMD_INS_POS && !stat.ins_pos_ok) begin
                code_nxt  = ST_BADPOS;
                state_nxt = S_STATUS;
              end else if (stat.full) begin
                code_nxt  = ST_FULL;
                state_nxt = S_STATUS;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            CMD_DEL_HEAD, CMD_DEL_POS, CMD_DEL_TAIL: begin
              if (stat.empty) begin
                code_nxt  = ST_EMPTY;
                state_nxt = S_STATUS;
              end else if (in_command == CMD_DEL_POS && !stat.del_pos_ok) begin
                code_nxt  = ST_BADPOS;
                state_nxt = S_STATUS;
              end else begin
                state_nxt = S_DEL_RD;
              end
            end
            CMD_DISPLAY: state_nxt = S_STREAM_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD:    state_nxt = stat.ptr_at_idx ? S_INS_PUT : S_INS_WR;
      S_INS_WR:    state_nxt = S_INS_RD;
      S_INS_PUT:   state_nxt = S_STREAM_RD;
      S_DEL_RD:    state_nxt = stat.ptr_at_end ? S_DEL_DONE : S_DEL_WR;
      S_DEL_WR:    state_nxt = S_DEL_RD;
      S_DEL_DONE:  state_nxt = S_STREAM_RD;
      S_STREAM_RD: begin
        if (stat.empty) begin
          code_nxt  = ST_EMPTY;
          state_nxt = S_STATUS;
        end else if (stat.out_free) begin
          state_nxt = S_STREAM_LD;
        end
      end
      S_STREAM_LD: state_nxt = stat.ptr_at_end ? S_IDLE : S_STREAM_RD;
      S_STATUS:    if (stat.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs: datapath operation and input stall.
  always_comb begin
    in_stall = (state_r != S_IDLE);
    cmd.op   = OP_NONE;
    cmd.code = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
              if (!(in_command == CMD_INS_POS && !stat.ins_pos_ok) && !stat.full) begin
                cmd.op = OP_START_INS;
              end
            end
            CMD_DEL_HEAD, CMD_DEL_POS, CMD_DEL_TAIL: begin
              if (!stat.empty && !(in_command == CMD_DEL_POS && !stat.del_pos_ok)) begin
                cmd.op = OP_START_DEL;
              end
            end
            CMD_DISPLAY: cmd.op = OP_REWIND;
            default:     cmd.op = OP_NONE;
          endcase
        end
      end
      S_INS_RD:    if (!stat.ptr_at_idx) cmd.op = OP_RD_PREV;
      S_INS_WR:    cmd.op = OP_WR_DOWN;
      S_INS_PUT:   cmd.op = OP_PUT;
      S_DEL_RD:    if (!stat.ptr_at_end) cmd.op = OP_RD_NEXT;
      S_DEL_WR:    cmd.op = OP_WR_UP;
      S_DEL_DONE:  cmd.op = OP_DEL_DONE;
      S_STREAM_RD: if (!stat.empty && stat.out_free) cmd.op = OP_RD_CUR;
      S_STREAM_LD: cmd.op = OP_EMIT;
      S_STATUS:    if (stat.out_free) cmd.op = OP_STATUS;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== sv/plid_dpath.sv =====
module plid_dpath
  import plid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  input  logic      out_stall,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_en, wr_en;
  logic [CNT_W-1:0] rd_ptr, wr_ptr;
  logic [VAL_W-1:0] wr_data;

  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0] start_idx;
  logic [CNT_W-1:0] ptr_inc, ptr_dec;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);

  // Target index of the incoming command.
  always_comb begin
    case (in_word.command)
      CMD_INS_POS, CMD_DEL_POS: start_idx = CNT_W'(in_word.position - POS_W'(1));
      CMD_INS_TAIL:             start_idx = len_r;
      CMD_DEL_TAIL:             start_idx = len_r - CNT_W'(1);
      default:                  start_idx = '0;
    endcase
  end

  // Status towards the controller.
  always_comb begin
    stat.empty      = (len_r == '0);
    stat.full       = (len_r == CNT_W'(CAPACITY));
    stat.ins_pos_ok = (in_word.position != '0) &&
                      ((POS_W + 1)'(in_word.position) <= (POS_W + 1)'(len_r) + (POS_W + 1)'(1));
    stat.del_pos_ok = (in_word.position != '0) &&
                      ((POS_W + 1)'(in_word.position) <= (POS_W + 1)'(len_r));
    stat.ptr_at_idx = (ptr_r == idx_r);
    stat.ptr_at_end = (ptr_inc == len_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Memory port control and register updates per operation.
  always_comb begin
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    rd_ptr        = ptr_r;
    wr_ptr        = ptr_r;
    wr_data       = rd_data_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    case (cmd.op)
      OP_START_INS: begin
        idx_nxt   = start_idx;
        ptr_nxt   = len_r;
        value_nxt = in_word.value;
      end
      OP_START_DEL: ptr_nxt = start_idx;
      OP_REWIND:    ptr_nxt = '0;
      OP_RD_PREV: begin
        rd_en  = 1'b1;
        rd_ptr = ptr_dec;
      end
      OP_WR_DOWN: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_dec;
      end
      OP_PUT: begin
        wr_en   = 1'b1;
        wr_ptr  = idx_r;
        wr_data = value_r;
        len_nxt = len_r + CNT_W'(1);
        ptr_nxt = '0;
      end
      OP_RD_NEXT: begin
        rd_en  = 1'b1;
        rd_ptr = ptr_inc;
      end
      OP_WR_UP: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_inc;
      end
      OP_DEL_DONE: begin
        len_nxt = len_r - CNT_W'(1);
        ptr_nxt = '0;
      end
      OP_RD_CUR: rd_en = 1'b1;
      OP_EMIT: begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.status        = ST_LISTED;
        out_word_nxt.element       = rd_data_r;
        out_word_nxt.element_count = CNT_OUT_W'(len_r);
        out_word_nxt.last          = (ptr_inc == len_r);
        ptr_nxt                    = ptr_inc;
      end
      OP_STATUS: begin
        out_valid_nxt              = 1'b1;
        out_word_nxt.status        = cmd.code;
        out_word_nxt.element       = '0;
        out_word_nxt.element_count = CNT_OUT_W'(len_r);
        out_word_nxt.last          = 1'b1;
      end
      default: ;
    endcase
  end

  // List storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr[AW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    value_r    <= value_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
